### rtl/lcvm_pkg.sv
// Shared widths, item types and register codes for the line clip and viewport map unit.
// No dependencies; imported by line_clip_and_viewport_map_unit, the only file in rtl/ that uses it.
package lcvm_pkg;

  // coordinate and parameter formats
  localparam int CW     = 16;          // coordinate width
  localparam int FB     = 16;          // fraction bits of te/tl
  localparam int DIFF_W = CW + 1;      // endpoint difference, edge p/q
  localparam int MAG_W  = CW;          // magnitude of a difference
  localparam int RQ_W   = FB + 1;      // ratio quotient bits
  localparam int T_W    = FB + 1;      // te/tl, 0 .. 1.0
  localparam int R_W    = FB + 3;      // signed ratio incl. saturation value
  localparam int P_W    = MAG_W + T_W; // lerp product
  localparam int C_W    = CW + 2;      // clipped point before truncation
  localparam int A_W    = CW + 3;      // point minus window min
  localparam int N_W    = A_W + MAG_W; // map numerator, also map quotient bits
  localparam int V_W    = N_W + 2;     // viewport value before saturation
  localparam int CFG_IDX_W = 4;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic                 visible;
    logic signed [CW-1:0] clip_start_x;
    logic signed [CW-1:0] clip_start_y;
    logic signed [CW-1:0] clip_end_x;
    logic signed [CW-1:0] clip_end_y;
    logic signed [CW-1:0] view_start_x;
    logic signed [CW-1:0] view_start_y;
    logic signed [CW-1:0] view_end_x;
    logic signed [CW-1:0] view_end_y;
  } res_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_X_MIN  = 4'd0,
    REG_WIN_X_MAX  = 4'd1,
    REG_WIN_Y_MIN  = 4'd2,
    REG_WIN_Y_MAX  = 4'd3,
    REG_VIEW_X_MIN = 4'd4,
    REG_VIEW_X_MAX = 4'd5,
    REG_VIEW_Y_MIN = 4'd6,
    REG_VIEW_Y_MAX = 4'd7
  } cfg_reg_t;

endpackage

### rtl/lcvm_div_cell.sv
// One restoring division step: brings in a numerator bit, trial subtracts, shifts in a quotient bit.
// Uses no package items; instantiated by lcvm_div_chain.
module lcvm_div_cell #(
  parameter int NW = 17,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic [DW-1:0] rem_in,
  input  logic [NW-1:0] num_in,
  input  logic [NW-1:0] quot_in,
  input  logic [DW-1:0] den_in,
  output logic [DW-1:0] rem_out,
  output logic [NW-1:0] num_out,
  output logic [NW-1:0] quot_out,
  output logic [DW-1:0] den_out
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // trial remainder and compare against the divisor
  always_comb begin
    trial = {rem_in, num_in[NW-1]};
    diff  = trial - {1'b0, den_in};
    ge    = trial >= {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    rem_out  <= ge ? diff[DW-1:0] : trial[DW-1:0];
    num_out  <= num_in << 1;
    quot_out <= {quot_in[NW-2:0], ge};
    den_out  <= den_in;
  end

endmodule

### rtl/lcvm_div_chain.sv
// Row of NW division cells, each registered; the quotient of {rem_init, num} / den leaves the last cell.
// Depends on lcvm_div_cell. rem_init must be below den for a valid quotient.
module lcvm_div_chain #(
  parameter int NW = 17,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic [DW-1:0] rem_init,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quot
);

  logic [DW-1:0] rem_s  [NW+1];
  logic [NW-1:0] num_s  [NW+1];
  logic [NW-1:0] quot_s [NW+1];
  logic [DW-1:0] den_s  [NW+1];

  assign rem_s[0]  = rem_init;
  assign num_s[0]  = num;
  assign quot_s[0] = '0;
  assign den_s[0]  = den;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    lcvm_div_cell #(.NW(NW), .DW(DW)) u_cell (
      .clk      (clk),
      .rem_in   (rem_s[i]),
      .num_in   (num_s[i]),
      .quot_in  (quot_s[i]),
      .den_in   (den_s[i]),
      .rem_out  (rem_s[i+1]),
      .num_out  (num_s[i+1]),
      .quot_out (quot_s[i+1]),
      .den_out  (den_s[i+1])
    );
  end

  assign quot = quot_s[NW];

endmodule

### rtl/line_clip_and_viewport_map_unit.sv
// Liang-Barsky segment clipper with window-to-viewport mapping, fully pipelined.
// Depends on lcvm_pkg and lcvm_div_chain (rows of lcvm_div_cell).
//
// A new segment is taken every clock (busy stays low) and its result appears on
// result with done high for one cycle; the receiver cannot stall, so results must
// be taken as they come. The path runs through two rows of division cells, one
// quotient bit per cell: 17 cells for the edge ratios and 35 cells for the viewport
// scaling, plus six register stages. Window and viewport registers may only be
// written while no segment is in flight.
module line_clip_and_viewport_map_unit
  import lcvm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  seg_t                 in_item,
  output logic                 done,
  output res_t                 result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_data
);

  localparam int NR  = RQ_W;  // ratio division cells
  localparam int NM  = N_W;   // map division cells
  localparam int LAT = 1 + NR + 4 + NM + 1;

  typedef struct packed {
    logic pzero;
    logic pneg;
    logic qneg;
    logic sat;
  } edge_flags_t;

  typedef struct packed {
    logic signed [CW-1:0]     x0;
    logic signed [CW-1:0]     y0;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    edge_flags_t [3:0]        flags;
  } side_a_t;

  typedef struct packed {
    logic                 vis;
    logic [3:0][CW-1:0]   clip;
    logic [3:0]           neg;
  } side_b_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] n;
    n = -v;
    return v[DIFF_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [CW-1:0] wx_min, wx_max, wy_min, wy_max;
  logic signed [CW-1:0] vx_min, vx_max, vy_min, vy_max;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;  // one item enters every cycle

  always_ff @(posedge clk) begin
    if (rst) begin
      wx_min <= 16'sd0;
      wx_max <= 16'sd511;
      wy_min <= 16'sd0;
      wy_max <= 16'sd511;
      vx_min <= 16'sd0;
      vx_max <= 16'sd511;
      vy_min <= 16'sd0;
      vy_max <= 16'sd511;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIN_X_MIN:  wx_min <= cfg_data;
        REG_WIN_X_MAX:  wx_max <= cfg_data;
        REG_WIN_Y_MIN:  wy_min <= cfg_data;
        REG_WIN_Y_MAX:  wy_max <= cfg_data;
        REG_VIEW_X_MIN: vx_min <= cfg_data;
        REG_VIEW_X_MAX: vx_max <= cfg_data;
        REG_VIEW_Y_MIN: vy_min <= cfg_data;
        REG_VIEW_Y_MAX: vy_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // window and viewport spans; the user must keep them static while items are in flight, the block does not enforce it
  logic signed [DIFF_W-1:0] dwx, dwy, dvx, dvy;
  logic                     win_zero;
  assign dwx = DIFF_W'(wx_max) - DIFF_W'(wx_min);
  assign dwy = DIFF_W'(wy_max) - DIFF_W'(wy_min);
  assign dvx = DIFF_W'(vx_max) - DIFF_W'(vx_min);
  assign dvy = DIFF_W'(vy_max) - DIFF_W'(vy_min);
  assign win_zero = (wx_max == wx_min) || (wy_max == wy_min);

  // ---------------------------------------------------------------- stage 0: edge p/q
  logic signed [DIFF_W-1:0] dx_c, dy_c;
  logic signed [DIFF_W-1:0] p_c [4];
  logic signed [DIFF_W-1:0] q_c [4];

  always_comb begin
    dx_c = DIFF_W'(in_item.end_x) - DIFF_W'(in_item.start_x);
    dy_c = DIFF_W'(in_item.end_y) - DIFF_W'(in_item.start_y);
    p_c[0] = -dx_c;
    q_c[0] = DIFF_W'(in_item.start_x) - DIFF_W'(wx_min);
    p_c[1] = dx_c;
    q_c[1] = DIFF_W'(wx_max) - DIFF_W'(in_item.start_x);
    p_c[2] = -dy_c;
    q_c[2] = DIFF_W'(in_item.start_y) - DIFF_W'(wy_min);
    p_c[3] = dy_c;
    q_c[3] = DIFF_W'(wy_max) - DIFF_W'(in_item.start_y);
  end

  logic             s0_valid;
  logic [MAG_W-1:0] s0_uq [4];
  logic [MAG_W-1:0] s0_up [4];
  side_a_t          s0_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_side.x0 <= in_item.start_x;
    s0_side.y0 <= in_item.start_y;
    s0_side.dx <= dx_c;
    s0_side.dy <= dy_c;
    for (int k = 0; k < 4; k++) begin
      s0_uq[k]               <= mag(q_c[k]);
      s0_up[k]               <= mag(p_c[k]);
      s0_side.flags[k].pzero <= p_c[k] == '0;
      s0_side.flags[k].pneg  <= p_c[k][DIFF_W-1];
      s0_side.flags[k].qneg  <= q_c[k][DIFF_W-1];
      s0_side.flags[k].sat   <= {1'b0, mag(q_c[k])} >= {mag(p_c[k]), 1'b0};
    end
  end

  // ---------------------------------------------------------------- ratio rows
  // |q| < 2|p| when used, so half of |q| is a valid starting remainder
  logic [RQ_W-1:0] rq [4];

  for (genvar k = 0; k < 4; k++) begin : g_ratio
    lcvm_div_chain #(.NW(NR), .DW(MAG_W)) u_ratio (
      .clk      (clk),
      .rem_init (s0_uq[k] >> 1),
      .num      ({s0_uq[k][0], {(NR-1){1'b0}}}),
      .den      (s0_up[k]),
      .quot     (rq[k])
    );
  end

  side_a_t        sa_line [NR];
  logic [NR-1:0]  va_line;

  always_ff @(posedge clk) begin
    sa_line[0] <= s0_side;
    for (int i = 1; i < NR; i++) sa_line[i] <= sa_line[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) va_line <= '0;
    else     va_line <= {va_line[NR-2:0], s0_valid};
  end

  // ---------------------------------------------------------------- edge tests
  side_a_t               sa_out;
  logic signed [R_W-1:0] r_c [4];
  logic                  ok_c;
  logic [T_W-1:0]        te_c, tl_c;

  assign sa_out = sa_line[NR-1];

  always_comb begin
    logic [R_W-1:0] m;
    for (int k = 0; k < 4; k++) begin
      m = sa_out.flags[k].sat ? R_W'(1) << (FB + 1) : R_W'(rq[k]);
      r_c[k] = (sa_out.flags[k].qneg != sa_out.flags[k].pneg) ? -$signed(m) : $signed(m);
    end
    ok_c = 1'b1;
    te_c = '0;
    tl_c = T_W'(1) << FB;
    // left, right, bottom, top in turn
    for (int k = 0; k < 4; k++) begin
      if (ok_c) begin
        if (sa_out.flags[k].pzero) begin
          ok_c = !sa_out.flags[k].qneg;
        end else if (sa_out.flags[k].pneg) begin
          if (r_c[k] > $signed({2'b00, tl_c})) ok_c = 1'b0;
          else if (r_c[k] > $signed({2'b00, te_c})) te_c = r_c[k][T_W-1:0];
        end else begin
          if (r_c[k] < $signed({2'b00, te_c})) ok_c = 1'b0;
          else if (r_c[k] < $signed({2'b00, tl_c})) tl_c = r_c[k][T_W-1:0];
        end
      end
    end
  end

  logic                     e_valid, e_vis;
  logic [T_W-1:0]           e_te, e_tl;
  logic signed [CW-1:0]     e_x0, e_y0;
  logic signed [DIFF_W-1:0] e_dx, e_dy;

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else     e_valid <= va_line[NR-1];
  end

  always_ff @(posedge clk) begin
    e_vis <= ok_c && !win_zero;
    e_te  <= te_c;
    e_tl  <= tl_c;
    e_x0  <= sa_out.x0;
    e_y0  <= sa_out.y0;
    e_dx  <= sa_out.dx;
    e_dy  <= sa_out.dy;
  end

  // ---------------------------------------------------------------- lerp products
  // order: start x, start y, end x, end y
  logic             l1_valid, l1_vis;
  logic [P_W-1:0]   l1_prod [4];
  logic signed [CW-1:0] l1_x0, l1_y0;
  logic             l1_dxneg, l1_dyneg;

  always_ff @(posedge clk) begin
    if (rst) l1_valid <= 1'b0;
    else     l1_valid <= e_valid;
  end

  always_ff @(posedge clk) begin
    l1_vis     <= e_vis;
    l1_prod[0] <= P_W'(mag(e_dx)) * P_W'(e_te);
    l1_prod[1] <= P_W'(mag(e_dy)) * P_W'(e_te);
    l1_prod[2] <= P_W'(mag(e_dx)) * P_W'(e_tl);
    l1_prod[3] <= P_W'(mag(e_dy)) * P_W'(e_tl);
    l1_x0      <= e_x0;
    l1_y0      <= e_y0;
    l1_dxneg   <= e_dx[DIFF_W-1];
    l1_dyneg   <= e_dy[DIFF_W-1];
  end

  // ---------------------------------------------------------------- round and offset
  logic                 l2_valid, l2_vis;
  logic signed [C_W-1:0] l2_c [4];

  always_ff @(posedge clk) begin
    if (rst) l2_valid <= 1'b0;
    else     l2_valid <= l1_valid;
  end

  always_ff @(posedge clk) begin
    logic [P_W:0]         rnd;
    logic [C_W-1:0]       m;
    logic signed [C_W-1:0] base;
    logic                 neg;
    l2_vis <= l1_vis;
    for (int k = 0; k < 4; k++) begin
      rnd  = {1'b0, l1_prod[k]} + ((P_W+1)'(1) << (FB - 1));
      m    = C_W'(rnd >> FB);
      base = (k % 2 == 0) ? C_W'(l1_x0) : C_W'(l1_y0);
      neg  = (k % 2 == 0) ? l1_dxneg : l1_dyneg;
      l2_c[k] <= neg ? base - $signed(m) : base + $signed(m);
    end
  end

  // ---------------------------------------------------------------- map numerator
  logic [N_W-1:0] m1_num [4];
  side_b_t        m1_side;
  logic           m1_valid;

  always_ff @(posedge clk) begin
    if (rst) m1_valid <= 1'b0;
    else     m1_valid <= l2_valid;
  end

  always_ff @(posedge clk) begin
    logic signed [A_W-1:0] a;
    logic signed [A_W-1:0] na;
    logic [A_W-1:0]        ma;
    logic [MAG_W-1:0]      mb;
    logic                  nb, nd;
    m1_side.vis <= l2_vis;
    for (int k = 0; k < 4; k++) begin
      a  = A_W'(l2_c[k]) - ((k % 2 == 0) ? A_W'(wx_min) : A_W'(wy_min));
      na = -a;
      ma = a[A_W-1] ? na : a;
      mb = (k % 2 == 0) ? mag(dvx) : mag(dvy);
      nb = (k % 2 == 0) ? dvx[DIFF_W-1] : dvy[DIFF_W-1];
      nd = (k % 2 == 0) ? dwx[DIFF_W-1] : dwy[DIFF_W-1];
      m1_num[k]       <= N_W'(ma) * N_W'(mb);
      m1_side.neg[k]  <= a[A_W-1] ^ nb ^ nd;
      m1_side.clip[k] <= l2_c[k][CW-1:0];
    end
  end

  // ---------------------------------------------------------------- map rows
  logic [N_W-1:0] mq [4];

  for (genvar k = 0; k < 4; k++) begin : g_map
    lcvm_div_chain #(.NW(NM), .DW(MAG_W)) u_map (
      .clk      (clk),
      .rem_init ('0),
      .num      (m1_num[k]),
      .den      ((k % 2 == 0) ? mag(dwx) : mag(dwy)),
      .quot     (mq[k])
    );
  end

  side_b_t       sb_line [NM];
  logic [NM-1:0] vb_line;

  always_ff @(posedge clk) begin
    sb_line[0] <= m1_side;
    for (int i = 1; i < NM; i++) sb_line[i] <= sb_line[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) vb_line <= '0;
    else     vb_line <= {vb_line[NM-2:0], m1_valid};
  end

  // ---------------------------------------------------------------- viewport add, saturate
  side_b_t              sb_out;
  logic signed [CW-1:0] view_c [4];

  assign sb_out = sb_line[NM-1];

  always_comb begin
    logic signed [V_W-1:0] v;
    logic signed [V_W-1:0] vmin;
    for (int k = 0; k < 4; k++) begin
      vmin = (k % 2 == 0) ? V_W'(vx_min) : V_W'(vy_min);
      v = sb_out.neg[k] ? vmin - $signed({2'b00, mq[k]}) : vmin + $signed({2'b00, mq[k]});
      if (v < -$signed(V_W'(1) << (CW - 1)))
        view_c[k] = {1'b1, {(CW-1){1'b0}}};
      else if (v > $signed((V_W'(1) << (CW - 1)) - V_W'(1)))
        view_c[k] = {1'b0, {(CW-1){1'b1}}};
      else
        view_c[k] = v[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vb_line[NM-1];
  end

  always_ff @(posedge clk) begin
    if (sb_out.vis) begin
      result.visible      <= 1'b1;
      result.clip_start_x <= sb_out.clip[0];
      result.clip_start_y <= sb_out.clip[1];
      result.clip_end_x   <= sb_out.clip[2];
      result.clip_end_y   <= sb_out.clip[3];
      result.view_start_x <= view_c[0];
      result.view_start_y <= view_c[1];
      result.view_end_x   <= view_c[2];
      result.view_end_y   <= view_c[3];
    end else begin
      result <= '0;
    end
  end

  // ---------------------------------------------------------------- checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("accepted item did not produce a result at the pipeline latency");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.visible |-> result.clip_start_x == '0 && result.clip_end_y == '0
                                && result.view_start_x == '0 && result.view_end_y == '0)
    else $error("rejected segment carries nonzero coordinates");

endmodule
